FILE: hdl/fmpf_pkg.sv
// Shared types, constants and match functions for the first-match packet filter.
// Used by the controller, datapath and top level of the filter; depends on nothing else.
package fmpf_pkg;

    localparam int RULES_DEFAULT = 64;

    localparam logic [7:0] PROTO_ANY  = 8'd0;
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam logic [5:0] PREFIX_FULL = 6'd32;

    localparam logic MODE_APPEND   = 1'b0;
    localparam logic MODE_CLASSIFY = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    localparam logic VERDICT_DROP   = 1'b0;
    localparam logic VERDICT_ACCEPT = 1'b1;

    // Input word, first field in the lowest bits.
    typedef struct packed {
        logic [2:0]  pad;
        logic        rule_action;
        logic [15:0] dst_port;
        logic [15:0] src_port;
        logic [7:0]  protocol;
        logic [5:0]  dst_prefix;
        logic [5:0]  src_prefix;
        logic [31:0] dst_addr;
        logic [31:0] src_addr;
    } t_in_data;

    typedef struct packed {
        logic direction;
        logic mode;
    } t_in_user;

    // Result word, first field in the lowest bits.
    typedef struct packed {
        logic [6:0] pad;
        logic       status;
        logic [5:0] rule_number;
        logic       matched;
        logic       verdict;
    } t_out_data;

    localparam int IN_DATA_W  = $bits(t_in_data);
    localparam int IN_USER_W  = $bits(t_in_user);
    localparam int OUT_DATA_W = $bits(t_out_data);

    // One stored rule; addresses are kept pre-masked, masks as prefix lengths.
    typedef struct packed {
        logic [31:0] src_value;
        logic [31:0] dst_value;
        logic [5:0]  src_prefix;
        logic [5:0]  dst_prefix;
        logic [7:0]  proto;
        logic [15:0] port;
        logic        verdict;
    } t_rule;

    localparam int RULE_W = $bits(t_rule);

    // Controller to datapath.
    typedef struct packed {
        logic start;
        logic write;
        logic issue;
        logic capture;
        logic load;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic full;
        logic more;
        logic walk_done;
        logic out_free;
    } t_sts;

    function automatic logic [31:0] prefix_mask(input logic [5:0] p);
        logic [5:0] sat;
        sat = (p > PREFIX_FULL) ? PREFIX_FULL : p;
        return ~(32'hFFFF_FFFF >> sat);
    endfunction

    function automatic logic rule_hit(input t_rule r, input logic [31:0] sa,
                                      input logic [31:0] da, input logic [7:0] proto,
                                      input logic [15:0] sp, input logic [15:0] dp);
        logic [31:0] ms;
        logic [31:0] md;
        logic        src_eq;
        logic        dst_eq;
        logic        src_any;
        logic        dst_any;
        logic        addr_ok;
        logic        proto_ok;
        ms      = sa & prefix_mask(r.src_prefix);
        md      = da & prefix_mask(r.dst_prefix);
        src_eq  = (ms == r.src_value);
        dst_eq  = (md == r.dst_value);
        src_any = (r.src_value == 32'd0);
        dst_any = (r.dst_value == 32'd0);
        addr_ok = (src_eq && (dst_any || dst_eq)) || (dst_eq && (src_any || src_eq)) ||
                  (src_any && dst_any);
        if (r.proto == PROTO_ANY) begin
            proto_ok = 1'b1;
        end else if (r.proto != proto) begin
            proto_ok = 1'b0;
        end else if (r.proto == PROTO_ICMP) begin
            proto_ok = 1'b1;
        end else if (r.proto == PROTO_TCP || r.proto == PROTO_UDP) begin
            proto_ok = (r.port == sp) || (r.port == dp);
        end else begin
            proto_ok = 1'b0;
        end
        return addr_ok && proto_ok;
    endfunction

endpackage

FILE: hdl/fmpf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the rule store; no dependencies.
module fmpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/fmpf_ctrl.sv
// Sequencer for the packet filter: accepts a word, runs append or rule walk, delivers.
// Depends on fmpf_pkg for the command and status structs.
module fmpf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_mode,
    output logic          o_in_ready,
    input  fmpf_pkg::t_sts i_sts,
    output fmpf_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPEND,
        ST_WALK,
        ST_DELIVER
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = (i_in_mode == fmpf_pkg::MODE_CLASSIFY) ? ST_WALK : ST_APPEND;
                end
            end
            ST_APPEND: begin
                o_cmd.write   = !i_sts.full;
                o_cmd.capture = 1'b1;
                n_state       = ST_DELIVER;
            end
            ST_WALK: begin
                if (i_sts.walk_done) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_DELIVER;
                end else begin
                    o_cmd.issue = 1'b1;
                end
            end
            ST_DELIVER: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

FILE: hdl/fmpf_dp.sv
// Datapath of the packet filter: input latch, rule counts, rule store, match, output register.
// Depends on fmpf_pkg and fmpf_ram.
module fmpf_dp #(
    parameter int RULES = fmpf_pkg::RULES_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [fmpf_pkg::IN_DATA_W-1:0]  i_in_data,
    input  logic [fmpf_pkg::IN_USER_W-1:0]  i_in_user,
    input  fmpf_pkg::t_cmd                  i_cmd,
    output fmpf_pkg::t_sts                  o_sts,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [fmpf_pkg::OUT_DATA_W-1:0] o_out_data
);

    localparam int IW = $clog2(RULES + 1);
    localparam int AW = $clog2(2 * RULES);

    fmpf_pkg::t_in_data  r_in;
    fmpf_pkg::t_in_user  r_user;
    logic [IW-1:0]       r_count [2];
    logic [IW-1:0]       r_idx;
    logic                r_chk_valid;
    logic [IW-1:0]       r_chk_idx;
    fmpf_pkg::t_out_data r_res;
    fmpf_pkg::t_out_data n_res;
    logic                r_out_valid;
    fmpf_pkg::t_out_data r_out_data;

    logic [IW-1:0]   count_sel;
    logic [AW-1:0]   base;
    logic [AW-1:0]   waddr;
    logic [AW-1:0]   raddr;
    fmpf_pkg::t_rule wrule;
    fmpf_pkg::t_rule rrule;
    logic            hit_now;

    assign count_sel = r_count[r_user.direction];
    assign base      = r_user.direction ? AW'(RULES) : '0;
    assign waddr     = base + AW'(count_sel);
    assign raddr     = base + AW'(r_idx);

    always_comb begin
        wrule.src_value  = r_in.src_addr & fmpf_pkg::prefix_mask(r_in.src_prefix);
        wrule.dst_value  = r_in.dst_addr & fmpf_pkg::prefix_mask(r_in.dst_prefix);
        wrule.src_prefix = r_in.src_prefix;
        wrule.dst_prefix = r_in.dst_prefix;
        wrule.proto      = r_in.protocol;
        wrule.port       = r_in.src_port;
        wrule.verdict    = r_in.rule_action;
    end

    fmpf_ram #(
        .WIDTH (fmpf_pkg::RULE_W),
        .DEPTH (2 * RULES)
    ) u_rules (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write),
        .i_waddr (waddr),
        .i_wdata (wrule),
        .i_raddr (raddr),
        .o_rdata (rrule)
    );

    assign hit_now = r_chk_valid && fmpf_pkg::rule_hit(rrule, r_in.src_addr, r_in.dst_addr,
                                                       r_in.protocol, r_in.src_port,
                                                       r_in.dst_port);

    assign o_sts.full      = (count_sel == IW'(RULES));
    assign o_sts.more      = (r_idx < count_sel);
    assign o_sts.walk_done = hit_now || (r_idx >= count_sel);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_res = '0;
        if (r_user.mode == fmpf_pkg::MODE_APPEND) begin
            n_res.status = o_sts.full ? fmpf_pkg::STATUS_FULL : fmpf_pkg::STATUS_OK;
        end else begin
            n_res.status  = fmpf_pkg::STATUS_OK;
            n_res.matched = hit_now;
            if (hit_now) begin
                n_res.verdict     = rrule.verdict;
                n_res.rule_number = 6'(r_chk_idx);
            end else begin
                n_res.verdict = fmpf_pkg::VERDICT_ACCEPT;
            end
        end
    end

    // Payload: input latch, result and output data.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_in   <= fmpf_pkg::t_in_data'(i_in_data);
            r_user <= fmpf_pkg::t_in_user'(i_in_user);
        end
        if (i_cmd.issue) begin
            r_chk_idx <= r_idx;
        end
        if (i_cmd.capture) begin
            r_res <= n_res;
        end
        if (i_cmd.load) begin
            r_out_data <= r_res;
        end
    end

    // Control: counts, walk pointer, read-in-flight flag, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count[0]  <= '0;
            r_count[1]  <= '0;
            r_idx       <= '0;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.write) begin
                r_count[r_user.direction] <= count_sel + IW'(1);
            end
            if (i_cmd.start) begin
                r_idx       <= '0;
                r_chk_valid <= 1'b0;
            end else begin
                r_chk_valid <= i_cmd.issue;
                if (i_cmd.issue) begin
                    r_idx <= r_idx + IW'(1);
                end
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: hdl/first_match_packet_filter_core.sv
// Top level of the first-match packet filter: controller, datapath and checks.
// Depends on fmpf_pkg, fmpf_ctrl, fmpf_dp (which holds fmpf_ram).
//
// Usage:
//   Slave stream carries one command word. tuser selects the operation (append a
//   rule or classify a packet) and the table (inbound or outbound); tdata carries
//   addresses, prefixes, protocol, ports and the rule action.
//   Master stream returns one result word per command: verdict, matched flag,
//   index of the first matching rule and the table-full status of an append.
//   Commands are handled one at a time; tready drops after a word is taken.
//   Append: latch, write and capture, then load once the output register is free.
//   Classify walks the table in order; the rule store's single read port
//   delivers one rule per cycle and the walk stops at the first hit.
//   The result sits in an output register, so the next command is taken while
//   that result waits; a stalled receiver holds only the following result.
//   Reset clears both rule counts to zero, so both tables start empty; the rule
//   store itself needs no clearing pass since only entries below the count are read.
module first_match_packet_filter_core #(
    parameter int RULES = fmpf_pkg::RULES_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // src_addr, dst_addr, src_prefix, dst_prefix, protocol, src_port, dst_port,
    // rule_action, zero pad
    input  logic [fmpf_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // mode, direction
    input  logic [fmpf_pkg::IN_USER_W-1:0]  i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // verdict, matched, rule_number, status, zero pad
    output logic [fmpf_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);

    fmpf_pkg::t_cmd cmd;
    fmpf_pkg::t_sts sts;
    fmpf_pkg::t_in_user in_user;

    assign in_user = fmpf_pkg::t_in_user'(i_s_axis_tuser);

    // Sequence each command word through append or rule walk.
    fmpf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_mode  (in_user.mode),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Hold the rule tables and evaluate one rule per cycle.
    fmpf_dp #(
        .RULES (RULES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_s_axis_tdata),
        .i_in_user   (i_s_axis_tuser),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata)
    );

    // Never write into a full table.
    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.write |-> !sts.full)
        else $error("rule write into full table");

    // Never read beyond the rules held.
    a_no_read_past_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.issue |-> sts.more)
        else $error("rule read beyond table count");

    // Never overwrite a result the receiver has not taken.
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> sts.out_free)
        else $error("result register overwritten");

    // One command at a time: ready drops right after an accept.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("second command accepted while busy");

endmodule

FILE: verif/tb_first_match_packet_filter_core.sv
// Self-checking testbench for first_match_packet_filter_core: drives append and classify
// words on the slave stream and checks every result word against a built-in filter model.
// Depends on fmpf_pkg and the core RTL only.
module tb_first_match_packet_filter_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RULES        = fmpf_pkg::RULES_DEFAULT;
    localparam int WATCHDOG_LIMIT = 1500;
    localparam int DRAIN_CYCLES   = 100;

    typedef struct packed {
        fmpf_pkg::t_in_user user;
        fmpf_pkg::t_in_data data;
    } t_cmd_word;

    // One stored rule as the filter sees it: masked values plus their masks.
    typedef struct {
        logic [31:0] src_value;
        logic [31:0] src_mask;
        logic [31:0] dst_value;
        logic [31:0] dst_mask;
        logic [7:0]  proto;
        logic [15:0] port;
        logic        verdict;
    } t_acl_rule;

    logic               i_clk    = 1'b0;
    logic               i_rst_n  = 1'b0;
    logic               s_tvalid = 1'b0;
    fmpf_pkg::t_in_data s_tdata  = '0;
    fmpf_pkg::t_in_user s_tuser  = '0;
    logic               m_tready = 1'b0;
    logic               o_s_axis_tready;
    logic               o_m_axis_tvalid;
    logic [fmpf_pkg::OUT_DATA_W-1:0] o_m_axis_tdata;

    // Words waiting for the driver, and verdicts/status owed by the core, oldest first.
    t_cmd_word           cmd_words[$];
    fmpf_pkg::t_out_data predicted_replies[$];

    // Filter state as the core should hold it once each word is accepted.
    t_acl_rule acl_table[2][N_RULES];
    int        acl_fill[2];

    // Rules as the stimulus side has queued them; used to aim packets at real rules.
    t_acl_rule queued_rules[2][N_RULES];
    int        queued_fill[2];

    int   fault_count  = 0;
    int   src_hold     = 0;
    int   rx_hold      = 0;
    int   stall_cycles = 0;
    logic quiet_tail   = 1'b0;

    first_match_packet_filter_core #(
        .RULES(N_RULES)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Leading-ones mask of a prefix length; lengths past 32 act as 32.
    function automatic logic [31:0] prefix_ones(input logic [5:0] plen);
        int          keep;
        logic [63:0] ones;
        keep = (plen > fmpf_pkg::PREFIX_FULL) ? 32 : int'(plen);
        ones = 64'h0000_0000_FFFF_FFFF << (32 - keep);
        return ones[31:0];
    endfunction

    function automatic t_acl_rule make_rule(input fmpf_pkg::t_in_data d);
        t_acl_rule r;
        r.src_mask  = prefix_ones(d.src_prefix);
        r.dst_mask  = prefix_ones(d.dst_prefix);
        r.src_value = d.src_addr & r.src_mask;
        r.dst_value = d.dst_addr & r.dst_mask;
        r.proto     = d.protocol;
        r.port      = d.src_port;
        r.verdict   = d.rule_action;
        return r;
    endfunction

    // Apply one accepted word to the filter state and return the word the core owes.
    function automatic fmpf_pkg::t_out_data filter_step(input fmpf_pkg::t_in_user u,
                                                        input fmpf_pkg::t_in_data d);
        fmpf_pkg::t_out_data reply;
        t_acl_rule           e;
        int                  n;
        int                  slot;
        logic                found;
        logic [31:0]         ms;
        logic [31:0]         md;
        logic                addr_hit;
        logic                proto_hit;
        reply = '0;
        n     = acl_fill[u.direction];
        found = 1'b0;
        if (u.mode == fmpf_pkg::MODE_APPEND) begin
            if (n >= N_RULES) begin
                reply.status = fmpf_pkg::STATUS_FULL;
            end else begin
                acl_table[u.direction][n] = make_rule(d);
                acl_fill[u.direction]     = n + 1;
            end
        end else begin
            reply.verdict = fmpf_pkg::VERDICT_ACCEPT;
            for (slot = 0; slot < n && !found; slot++) begin
                e  = acl_table[u.direction][slot];
                ms = d.src_addr & e.src_mask;
                md = d.dst_addr & e.dst_mask;
                // A zero stored value is a wildcard even when its mask is not.
                addr_hit = (ms == e.src_value && (e.dst_value == 0 || md == e.dst_value)) ||
                           (md == e.dst_value && (e.src_value == 0 || ms == e.src_value)) ||
                           (e.src_value == 0 && e.dst_value == 0);
                if (e.proto == fmpf_pkg::PROTO_ANY) begin
                    proto_hit = 1'b1;
                end else if (e.proto != d.protocol) begin
                    proto_hit = 1'b0;
                end else if (e.proto == fmpf_pkg::PROTO_ICMP) begin
                    proto_hit = 1'b1;
                end else if (e.proto == fmpf_pkg::PROTO_TCP ||
                             e.proto == fmpf_pkg::PROTO_UDP) begin
                    proto_hit = (e.port == d.src_port) || (e.port == d.dst_port);
                end else begin
                    proto_hit = 1'b0;   // other protocols never match a specific rule
                end
                if (addr_hit && proto_hit) begin
                    found             = 1'b1;
                    reply.verdict     = e.verdict;
                    reply.matched     = 1'b1;
                    reply.rule_number = 6'(slot);
                end
            end
        end
        return reply;
    endfunction

    task automatic queue_word(input logic mode, input logic dir, input logic [31:0] sa,
                              input logic [31:0] da, input logic [5:0] spre,
                              input logic [5:0] dpre, input logic [7:0] proto,
                              input logic [15:0] sp, input logic [15:0] dp, input logic act);
        t_cmd_word w;
        w                  = '0;
        w.user.mode        = mode;
        w.user.direction   = dir;
        w.data.src_addr    = sa;
        w.data.dst_addr    = da;
        w.data.src_prefix  = spre;
        w.data.dst_prefix  = dpre;
        w.data.protocol    = proto;
        w.data.src_port    = sp;
        w.data.dst_port    = dp;
        w.data.rule_action = act;
        if (mode == fmpf_pkg::MODE_APPEND && queued_fill[dir] < N_RULES) begin
            queued_rules[dir][queued_fill[dir]] = make_rule(w.data);
            queued_fill[dir]++;
        end
        cmd_words.push_back(w);
    endtask

    function automatic logic [5:0] pick_prefix();
        case ($urandom_range(0, 7))
            0:       return 6'($urandom_range(0, 63));
            1:       return 6'd0;
            2:       return fmpf_pkg::PREFIX_FULL;
            default: return 6'($urandom_range(8, 32));
        endcase
    endfunction

    function automatic logic [7:0] pick_proto(input logic allow_any);
        int r;
        r = $urandom_range(0, 15);
        if (r == 0 && allow_any) return fmpf_pkg::PROTO_ANY;
        if (r <= 2)  return fmpf_pkg::PROTO_ICMP;
        if (r <= 8)  return fmpf_pkg::PROTO_TCP;
        if (r <= 13) return fmpf_pkg::PROTO_UDP;
        if (r == 14) return 8'd50;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic queue_random_rule(input logic dir);
        logic [31:0] sa;
        logic [31:0] da;
        logic [15:0] port;
        sa   = ($urandom_range(0, 11) == 0) ? 32'd0 : 32'($urandom);
        da   = ($urandom_range(0, 11) == 0) ? 32'd0 : 32'($urandom);
        port = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 1023)) : 16'($urandom);
        queue_word(fmpf_pkg::MODE_APPEND, dir, sa, da, pick_prefix(), pick_prefix(),
                   pick_proto(1'b1), port, 16'($urandom), 1'($urandom));
    endtask

    // Aim most packets at a stored rule, some with one field knocked off; the rest are noise.
    task automatic queue_probe(input logic dir);
        t_acl_rule   r;
        logic [31:0] sa;
        logic [31:0] da;
        logic [7:0]  proto;
        logic [15:0] sp;
        logic [15:0] dp;
        int          b;
        sa    = 32'($urandom);
        da    = 32'($urandom);
        proto = pick_proto(1'b0);
        sp    = 16'($urandom);
        dp    = 16'($urandom);
        if (queued_fill[dir] > 0 && $urandom_range(0, 9) < 7) begin
            r  = queued_rules[dir][$urandom_range(0, queued_fill[dir] - 1)];
            sa = r.src_value | (sa & ~r.src_mask);
            da = r.dst_value | (da & ~r.dst_mask);
            if (r.proto != fmpf_pkg::PROTO_ANY) proto = r.proto;
            if ($urandom_range(0, 1) == 0) sp = r.port;
            else                           dp = r.port;
            if ($urandom_range(0, 4) == 0) begin
                b = $urandom_range(0, 31);
                case ($urandom_range(0, 3))
                    0: sa[b] = ~sa[b];
                    1: da[b] = ~da[b];
                    2: proto = proto ^ 8'd1;
                    default: begin
                        sp = sp + 16'd1;
                        dp = dp + 16'd1;
                    end
                endcase
            end
        end
        queue_word(fmpf_pkg::MODE_CLASSIFY, dir, sa, da, 6'($urandom), 6'($urandom), proto,
                   sp, dp, 1'($urandom));
    endtask

    task automatic queue_mix(input int count, input int append_pct);
        int k;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < append_pct) queue_random_rule(1'($urandom));
            else                                   queue_probe(1'($urandom));
        end
    endtask

    // Hold the sender until the core has returned every owed result word.
    task automatic drain_core();
        while (cmd_words.size() != 0 || s_tvalid || predicted_replies.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s expected %0d got %0d", name, want, got);
            fault_count++;
        end
    endtask

    // Driver: hold a word until taken, then advance; insert idle bursts between words.
    always @(posedge i_clk) begin
        t_cmd_word w;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            src_hold <= 0;
        end else begin
            if (s_tvalid && o_s_axis_tready) begin
                predicted_replies.push_back(filter_step(s_tuser, s_tdata));
            end
            if (!s_tvalid || o_s_axis_tready) begin
                if (src_hold > 0) begin
                    src_hold <= src_hold - 1;
                    s_tvalid <= 1'b0;
                end else if (cmd_words.size() > 0) begin
                    w        = cmd_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= w.data;
                    s_tuser  <= w.user;
                    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                        src_hold <= $urandom_range(1, 18);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each taken result word with the oldest owed one; stall tready in bursts.
    always @(posedge i_clk) begin
        fmpf_pkg::t_out_data got;
        fmpf_pkg::t_out_data want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            rx_hold  <= 0;
        end else begin
            if (o_m_axis_tvalid && m_tready) begin
                got = o_m_axis_tdata;
                if (predicted_replies.size() == 0) begin
                    $error("result word %h with no command outstanding", got);
                    fault_count++;
                end else begin
                    want = predicted_replies.pop_front();
                    check_field("verdict", want.verdict, got.verdict);
                    check_field("matched", want.matched, got.matched);
                    check_field("rule_number", want.rule_number, got.rule_number);
                    check_field("status", want.status, got.status);
                end
            end
            if (rx_hold > 0) begin
                rx_hold  <= rx_hold - 1;
                m_tready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
                rx_hold  <= $urandom_range(0, 17);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: a walk is bounded by the number of rules held, so a long silence means a hang.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int d;
        acl_fill[0]    = 0;
        acl_fill[1]    = 0;
        queued_fill[0] = 0;
        queued_fill[1] = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty tables, saturated and zero prefixes, every protocol class.
        queue_word(fmpf_pkg::MODE_CLASSIFY, 1'b0, 32'hFFFF_FFFF, 32'h0, 6'd0, 6'd63,
                   fmpf_pkg::PROTO_TCP, 16'hFFFF, 16'h0, 1'b1);
        queue_word(fmpf_pkg::MODE_CLASSIFY, 1'b1, 32'h0, 32'hFFFF_FFFF, 6'd63, 6'd0, 8'hFF,
                   16'h0, 16'hFFFF, 1'b0);
        // Inbound rule 0: exact source, destination wildcarded by a zero prefix, TCP.
        queue_word(fmpf_pkg::MODE_APPEND, 1'b0, 32'hFFFF_FFFF, 32'h1234_5678, 6'd63, 6'd0,
                   fmpf_pkg::PROTO_TCP, 16'hFFFF, 16'hFFFF, fmpf_pkg::VERDICT_DROP);
        queue_word(fmpf_pkg::MODE_CLASSIFY, 1'b0, 32'hFFFF_FFFF, 32'hA5A5_0001, 6'd0, 6'd0,
                   fmpf_pkg::PROTO_TCP, 16'hFFFF, 16'h0001, 1'b0);
        queue_word(fmpf_pkg::MODE_CLASSIFY, 1'b0, 32'hFFFF_FFFF, 32'h0, 6'd0, 6'd0,
                   fmpf_pkg::PROTO_TCP, 16'h0001, 16'hFFFF, 1'b0);
        queue_word(fmpf_pkg::MODE_CLASSIFY, 1'b0, 32'hFFFF_FFFF, 32'h0, 6'd0, 6'd0,
                   fmpf_pkg::PROTO_TCP, 16'h0, 16'h0, 1'b0);
        queue_word(fmpf_pkg::MODE_CLASSIFY, 1'b0, 32'hFFFF_FFFE, 32'h0, 6'd0, 6'd0,
                   fmpf_pkg::PROTO_TCP, 16'hFFFF, 16'hFFFF, 1'b0);
        // Inbound rule 1: full wildcard on an unsupported protocol never matches.
        queue_word(fmpf_pkg::MODE_APPEND, 1'b0, 32'h0, 32'h0, 6'd0, 6'd0, 8'd50,
                   16'd0, 16'd0, fmpf_pkg::VERDICT_ACCEPT);
        queue_word(fmpf_pkg::MODE_CLASSIFY, 1'b0, 32'h0102_0304, 32'h0, 6'd0, 6'd0, 8'd50,
                   16'd0, 16'd0, 1'b0);
        // Inbound rule 2: ICMP, /24 source, destination that masks down to zero.
        queue_word(fmpf_pkg::MODE_APPEND, 1'b0, 32'h0A00_0001, 32'h00FF_FFFF, 6'd24, 6'd8,
                   fmpf_pkg::PROTO_ICMP, 16'd7, 16'd0, fmpf_pkg::VERDICT_ACCEPT);
        queue_word(fmpf_pkg::MODE_CLASSIFY, 1'b0, 32'h0A00_00FF, 32'h5555_AAAA, 6'd0, 6'd0,
                   fmpf_pkg::PROTO_ICMP, 16'd1, 16'd2, 1'b0);
        queue_word(fmpf_pkg::MODE_CLASSIFY, 1'b0, 32'h0B00_0000, 32'h5555_AAAA, 6'd0, 6'd0,
                   fmpf_pkg::PROTO_ICMP, 16'd1, 16'd2, 1'b0);
        // Inbound rule 3: UDP, zero source value under a /32 mask acts as any.
        queue_word(fmpf_pkg::MODE_APPEND, 1'b0, 32'h0, 32'hC0A8_0000, 6'd32, 6'd16,
                   fmpf_pkg::PROTO_UDP, 16'd0, 16'd0, fmpf_pkg::VERDICT_DROP);
        queue_word(fmpf_pkg::MODE_CLASSIFY, 1'b0, 32'h1111_1111, 32'hC0A8_1234, 6'd0, 6'd0,
                   fmpf_pkg::PROTO_UDP, 16'd0, 16'd53, 1'b0);
        queue_word(fmpf_pkg::MODE_CLASSIFY, 1'b0, 32'h1111_1111, 32'hC0A9_0000, 6'd0, 6'd0,
                   fmpf_pkg::PROTO_UDP, 16'd9, 16'd0, 1'b0);
        // Outbound rule 0: any protocol, /1 source, destination prefix past 32.
        queue_word(fmpf_pkg::MODE_APPEND, 1'b1, 32'h8000_0000, 32'hFFFF_FFFF, 6'd1, 6'd40,
                   fmpf_pkg::PROTO_ANY, 16'd0, 16'd0, fmpf_pkg::VERDICT_ACCEPT);
        queue_word(fmpf_pkg::MODE_CLASSIFY, 1'b1, 32'h8765_4321, 32'hFFFF_FFFF, 6'd0, 6'd0,
                   8'h2A, 16'd0, 16'd0, 1'b0);
        queue_word(fmpf_pkg::MODE_CLASSIFY, 1'b1, 32'h7FFF_FFFF, 32'hFFFF_FFFE, 6'd0, 6'd0,
                   8'h2A, 16'd0, 16'd0, 1'b0);
        // Outbound rule 1: TCP wildcard addresses, so the first rule still wins on overlap.
        queue_word(fmpf_pkg::MODE_APPEND, 1'b1, 32'h0, 32'h0, 6'd0, 6'd0, fmpf_pkg::PROTO_TCP,
                   16'h8000, 16'd0, fmpf_pkg::VERDICT_DROP);
        queue_word(fmpf_pkg::MODE_CLASSIFY, 1'b1, 32'h0000_0001, 32'h0, 6'd0, 6'd0,
                   fmpf_pkg::PROTO_TCP, 16'd80, 16'h8000, 1'b0);
        queue_word(fmpf_pkg::MODE_CLASSIFY, 1'b1, 32'h8000_0001, 32'hFFFF_FFFF, 6'd0, 6'd0,
                   fmpf_pkg::PROTO_TCP, 16'h8000, 16'd80, 1'b0);

        // Fill both tables while probing them, then top up and knock on the full tables.
        queue_mix(320, 55);
        for (d = 0; d < 2; d++) begin
            while (queued_fill[d] < N_RULES) queue_random_rule(1'(d));
            queue_random_rule(1'(d));
        end
        drain_core();

        // Full tables: mostly classify with long walks, refused appends mixed in.
        queue_mix(920, 12);
        drain_core();

        // Tail with both sides streaming back to back.
        quiet_tail = 1'b1;
        queue_mix(180, 10);
        drain_core();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/fmpf_pkg.sv
hdl/fmpf_ram.sv
hdl/fmpf_ctrl.sv
hdl/fmpf_dp.sv
hdl/first_match_packet_filter_core.sv
verif/tb_first_match_packet_filter_core.sv
